[rtl/core/iib_pkg.sv]
// Shared types and constants of the integral image box mean filter.
// Used by the divider, the filter core and the checker; depends on nothing.
`default_nettype none
package iib_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int WIN_CFG_W = 5;
  localparam int POS_OUT_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int TAB_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd2;

  localparam logic [CFG_W-1:0]     IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0]     IMAGE_HEIGHT_RST = 11'd1024;
  localparam logic [WIN_CFG_W-1:0] WINDOW_WIDTH_RST = 5'd3;

endpackage
`default_nettype wire

[rtl/core/iib_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module iib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/iib_div.sv]
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in a pixel word. Depends on iib_pkg.
`default_nettype none
module iib_div #(
  parameter int SUM_W = 18,
  parameter int DIV_W = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [SUM_W-1:0]         dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [iib_pkg::PIX_W-1:0] quotient
);
  import iib_pkg::*;

  localparam int SH_W  = DIV_W + PIX_W;
  localparam int EXT_W = (SUM_W > SH_W) ? SUM_W : SH_W;
  localparam int CNT_W = $clog2(PIX_W + 1);

  logic [SUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  assign fits = EXT_W'(rem) >= EXT_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dsh      <= SH_W'(divisor) << (PIX_W - 1);
        cnt      <= CNT_W'(PIX_W);
        busy     <= 1'b1;
        quotient <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - SUM_W'(dsh);
        end
        quotient <= {quotient[PIX_W-2:0], fits};
        dsh      <= dsh >> 1;
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/integral_image_box_mean_filter_core.sv]
// Box mean filter over a summed-area table kept in a ring of table lines.
// Depends on iib_pkg, iib_ram and iib_div.
//
// Usage: pixels enter in raster order on the input channel (in_valid,
// in_stall, pixel, frame_start); a word is taken when in_valid is high and
// in_stall low. For each interior pixel whose box ends at the current pixel
// one word (mean, out_x, out_y) leaves on the output channel (out_valid,
// out_stall). Border pixels and a window width of 0 or 1 give no output.
// Each pixel does four reads and one write on the single table RAM, one
// access per cycle; a pixel with output then runs a divide for the mean.
// The block takes no new pixel until the last one is through (in_stall).
// Configuration (image_width, image_height, window_width) is written through
// cfg_we/cfg_index/cfg_data while no pixel is in flight.
// Reset clears position, running sum and out_valid and loads the
// default sizes; the table RAM needs no clearing. A stalled output word is
// held in the output register while the next pixel is already processed; that
// pixel then waits before its result until the register is free.
`default_nettype none
module integral_image_box_mean_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 31
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [iib_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iib_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [iib_pkg::PIX_W-1:0]        pixel,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iib_pkg::PIX_W-1:0]        mean,
  output logic [iib_pkg::POS_OUT_W-1:0]    out_x,
  output logic [iib_pkg::POS_OUT_W-1:0]    out_y
);
  import iib_pkg::*;

  localparam int RING     = MAX_WINDOW + 1;
  localparam int LINE_LEN = MAX_WIDTH + 1;
  localparam int DEPTH    = RING * LINE_LEN;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(MAX_WIDTH + 1);
  localparam int RW       = $clog2(MAX_HEIGHT + 1);
  localparam int SW       = $clog2(RING);
  localparam int WIN_CAP  = (MAX_WINDOW - 1) | 1;
  localparam int WW       = $clog2(WIN_CAP + 1);
  localparam int DIV_W    = $clog2(WIN_CAP * WIN_CAP + 1);
  localparam int SUM_W    = $clog2(255 * WIN_CAP * WIN_CAP + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WRITE, S_DIV, S_PUSH} state_t;

  // Configuration registers.
  logic [CFG_W-1:0]     img_w, img_h;
  logic [WIN_CFG_W-1:0] win;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= IMAGE_WIDTH_RST;
      img_h <= IMAGE_HEIGHT_RST;
      win   <= WINDOW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_w <= cfg_data;
        REG_IMAGE_HEIGHT: img_h <= cfg_data;
        REG_WINDOW_WIDTH: win   <= cfg_data[WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and window.
  logic [CW-1:0]        wid;
  logic [RW-1:0]        hgt;
  logic [WIN_CFG_W-1:0] win_odd;
  logic [WW-1:0]        w;
  logic                 win_en;

  always_comb begin
    if (img_w == '0)                    wid = CW'(1);
    else if (32'(img_w) > MAX_WIDTH)    wid = CW'(MAX_WIDTH);
    else                                wid = CW'(img_w);
    if (img_h == '0)                    hgt = RW'(1);
    else if (32'(img_h) > MAX_HEIGHT)   hgt = RW'(MAX_HEIGHT);
    else                                hgt = RW'(img_h);
    win_en  = win > WIN_CFG_W'(1);
    win_odd = win | WIN_CFG_W'(1);
    if (32'(win_odd) > WIN_CAP)         w = WW'(WIN_CAP);
    else                                w = WW'(win_odd);
  end

  // Position registers and row sum.
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [SW-1:0]    slot;
  logic [TAB_W-1:0] rs;

  // Position of the arriving pixel and the position after it.
  logic [CW-1:0]    x, x1, c0, col_next;
  logic [RW-1:0]    y, row_next;
  logic [SW-1:0]    sy, sy1, r0s, slot_next;
  logic [TAB_W-1:0] rs_next;
  logic             fit;
  int               r0_tmp;

  always_comb begin
    x  = col;
    y  = row;
    sy = slot;
    if (frame_start || row >= hgt) begin
      x  = '0;
      y  = '0;
      sy = '0;
    end
    if (x >= wid) begin
      x  = '0;
      y  = y + RW'(1);
      sy = (sy == SW'(RING - 1)) ? '0 : sy + SW'(1);
      if (y >= hgt) begin
        y  = '0;
        sy = '0;
      end
    end
    x1  = x + CW'(1);
    sy1 = (sy == SW'(RING - 1)) ? '0 : sy + SW'(1);
    c0  = x1 - CW'(w);
    r0_tmp = int'(sy1) - int'(w);
    if (r0_tmp < 0) r0_tmp = r0_tmp + RING;
    r0s = SW'(r0_tmp);
    fit = win_en && (32'(x1) >= 32'(w)) && (32'(y) + 32'd1 >= 32'(w));
    rs_next = ((x == '0) ? '0 : rs) + TAB_W'(pixel);
    col_next  = x1;
    row_next  = y;
    slot_next = sy;
    if (x1 >= wid) begin
      col_next  = '0;
      row_next  = y + RW'(1);
      slot_next = sy1;
      if (row_next >= hgt) begin
        row_next  = '0;
        slot_next = '0;
      end
    end
  end

  // Work registers of the pixel in flight.
  state_t           state;
  logic [2:0]       cnt;
  logic [SW-1:0]    p_sy, p_sy1, p_r0s;
  logic [CW-1:0]    p_x1, p_c0;
  logic [3:0]       p_zero;
  logic             p_fit;
  logic [DIV_W-1:0] p_area;
  logic [POS_OUT_W-1:0] p_ox, p_oy;
  logic [TAB_W-1:0] val, acc;

  // Table RAM.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [TAB_W-1:0] ram_rdata, rd_val;
  logic [SW-1:0]    sel_slot;
  logic [CW-1:0]    sel_col;

  always_comb begin
    case (cnt)
      3'd0:    begin sel_slot = p_sy;  sel_col = p_x1; end
      3'd1:    begin sel_slot = p_r0s; sel_col = p_x1; end
      3'd2:    begin sel_slot = p_sy1; sel_col = p_c0; end
      default: begin sel_slot = p_r0s; sel_col = p_c0; end
    endcase
    ram_raddr = AW'(int'(sel_slot) * LINE_LEN + int'(sel_col));
    ram_waddr = AW'(int'(p_sy1) * LINE_LEN + int'(p_x1));
    ram_we    = (state == S_WRITE);
    // Table row 0 and column 0 are zero and never come from the RAM.
    rd_val    = p_zero[cnt[1:0] - 2'd1] ? '0 : ram_rdata;
  end

  iib_ram #(.WIDTH(TAB_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Mean divider.
  logic             div_start, div_done;
  logic [PIX_W-1:0] div_q;

  assign div_start = (state == S_WRITE) && p_fit;

  iib_div #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (SUM_W'(acc)),
    .divisor  (p_area),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      col       <= '0;
      row       <= '0;
      slot      <= '0;
      rs        <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_PUSH the output register is either refilled or still stalled.
      if (out_valid && !out_stall && state != S_PUSH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            col    <= col_next;
            row    <= row_next;
            slot   <= slot_next;
            rs     <= rs_next;
            p_sy   <= sy;
            p_sy1  <= sy1;
            p_r0s  <= r0s;
            p_x1   <= x1;
            p_c0   <= c0;
            p_fit  <= fit;
            p_area <= DIV_W'(w * w);
            p_zero <= {(32'(y) + 32'd1 == 32'(w)) || (x1 == CW'(w)),
                       x1 == CW'(w),
                       32'(y) + 32'd1 == 32'(w),
                       y == '0};
            p_ox   <= POS_OUT_W'(x - CW'(w >> 1));
            p_oy   <= POS_OUT_W'(y - RW'(w >> 1));
            cnt    <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          cnt <= cnt + 3'd1;
          case (cnt)
            3'd0:    ;
            3'd1:    val <= rd_val + rs;
            3'd2:    acc <= val - rd_val;
            3'd3:    acc <= acc - rd_val;
            default: begin
              acc   <= acc + rd_val;
              state <= S_WRITE;
            end
          endcase
        end
        S_WRITE: begin
          state <= p_fit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            mean      <= div_q;
            out_x     <= p_ox;
            out_y     <= p_oy;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/iib_checker.sv]
// Port-level checks of the box mean filter core, bound to the top level.
// Depends on iib_pkg and integral_image_box_mean_filter_core.
`default_nettype none
module iib_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [iib_pkg::PIX_W-1:0]     mean,
  input logic [iib_pkg::POS_OUT_W-1:0] out_x,
  input logic [iib_pkg::POS_OUT_W-1:0] out_y
);
  import iib_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean) && $stable(out_x)
      && $stable(out_y))
    else $error("output word changed while stalled");

  // One pixel at a time: the block is busy right after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // A new result only appears while a pixel is being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in flight");

endmodule

bind integral_image_box_mean_filter_core iib_checker u_iib_checker (.*);
`default_nettype wire
